[hw/rtl/lzss_ring_decoder_top_defines.svh]
// Assertion helpers shared by the decoder RTL.
// Both expect clk_i and rst_ni in scope.
`ifndef LZSS_RING_DECODER_TOP_DEFINES_SVH
`define LZSS_RING_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define LZR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LZR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lzr_pkg.sv]
package lzr_pkg;

  localparam int unsigned RING_DEPTH  = 4096;
  localparam int unsigned MAX_MATCH   = 18;
  localparam int unsigned LENGTH_BIAS = 2;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FLAG_CNT_W  = 4;
  localparam logic [BYTE_W-1:0]     FILL_RESET      = 8'h20;
  localparam logic [FLAG_CNT_W-1:0] FLAGS_PER_GROUP = 4'd8;

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } lzr_state_e;

  // one byte request from the parser into the emit stage
  typedef struct packed {
    logic              valid;
    logic              from_mem;
    logic [BYTE_W-1:0] lit;
    logic              run_last;
    logic              blk_end;
  } lzr_req_t;

  typedef struct packed {
    logic take;     // input word accepted
    logic restart;  // block ends on a word that emits nothing
  } lzr_ctl_t;

  typedef struct packed {
    logic req_ready;
    logic idle;
  } lzr_emit_st_t;

endpackage

[hw/rtl/lzr_in_if.sv]
interface lzr_in_if;
  logic                      valid;
  logic                      ready;
  logic [lzr_pkg::BYTE_W-1:0] in_byte;
  logic                      in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[hw/rtl/lzr_out_if.sv]
interface lzr_out_if;
  logic                      valid;
  logic                      ready;
  logic [lzr_pkg::BYTE_W-1:0] out_byte;
  logic                      out_run_last;

  modport source (output valid, output out_byte, output out_run_last, input ready);
  modport sink   (input valid, input out_byte, input out_run_last, output ready);
endinterface

[hw/rtl/lzr_cfg_if.sv]
interface lzr_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lzr_pkg::BYTE_W-1:0] fill_byte;

  modport source (output valid, output fill_byte, input ready);
  modport sink   (input valid, input fill_byte, output ready);
endinterface

[hw/rtl/lzr_ring_mem.sv]
module lzr_ring_mem #(
  parameter int unsigned RING_DEPTH = lzr_pkg::RING_DEPTH,
  localparam int unsigned AW = $clog2(RING_DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [lzr_pkg::BYTE_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [lzr_pkg::BYTE_W-1:0] rdata_o
);

  logic [lzr_pkg::BYTE_W-1:0] mem_q [RING_DEPTH];
  logic [lzr_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-before-write; same-address collisions are forwarded by the caller
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/lzr_parser.sv]
`include "lzss_ring_decoder_top_defines.svh"

module lzr_parser #(
  parameter int unsigned RING_DEPTH  = lzr_pkg::RING_DEPTH,
  parameter int unsigned MAX_MATCH   = lzr_pkg::MAX_MATCH,
  parameter int unsigned LENGTH_BIAS = lzr_pkg::LENGTH_BIAS,
  localparam int unsigned AW = $clog2(RING_DEPTH),
  localparam int unsigned LW = $clog2(MAX_MATCH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lzr_in_if.sink                in_i,
  input  lzr_pkg::lzr_emit_st_t emit_st_i,
  output lzr_pkg::lzr_req_t     req_o,
  output logic [AW-1:0]         req_addr_o,
  output lzr_pkg::lzr_ctl_t     ctl_o
);

  lzr_pkg::lzr_state_e state_q, state_d;
  logic [lzr_pkg::BYTE_W-1:0]     flag_bits_q, flag_bits_d;
  logic [lzr_pkg::FLAG_CNT_W-1:0] flags_left_q, flags_left_d;
  logic                           await_hi_q, await_hi_d;
  logic [lzr_pkg::BYTE_W-1:0]     low_q, low_d;
  logic [AW-1:0]                  rd_pos_q, rd_pos_d;
  logic [LW-1:0]                  remain_q, remain_d;
  logic                           mlast_q, mlast_d;

  logic accept;
  logic is_flag, is_hi, is_lit, is_lo;

  assign is_flag = (flags_left_q == '0);
  assign is_hi   = !is_flag && await_hi_q;
  assign is_lit  = !is_flag && !await_hi_q && flag_bits_q[0];
  assign is_lo   = !is_flag && !await_hi_q && !flag_bits_q[0];

  assign in_i.ready = (state_q == lzr_pkg::ST_IDLE) && emit_st_i.idle;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    state_d      = state_q;
    flag_bits_d  = flag_bits_q;
    flags_left_d = flags_left_q;
    await_hi_d   = await_hi_q;
    low_d        = low_q;
    rd_pos_d     = rd_pos_q;
    remain_d     = remain_q;
    mlast_d      = mlast_q;

    req_o          = '0;
    req_addr_o     = rd_pos_q;
    ctl_o.take     = accept;
    ctl_o.restart  = accept && in_i.in_last && (is_flag || is_lo);

    unique case (state_q)
      lzr_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (is_flag) begin
            flag_bits_d  = in_i.in_byte;
            flags_left_d = lzr_pkg::FLAGS_PER_GROUP;
          end else if (is_hi) begin
            // 12-bit position: low byte plus high nibble of this byte
            rd_pos_d     = AW'({in_i.in_byte[7:4], low_q});
            remain_d     = LW'(in_i.in_byte[3:0]) + LW'(LENGTH_BIAS + 1);
            mlast_d      = in_i.in_last;
            await_hi_d   = 1'b0;
            flag_bits_d  = flag_bits_q >> 1;
            flags_left_d = flags_left_q - 1'b1;
            state_d      = lzr_pkg::ST_COPY;
          end else if (is_lit) begin
            req_o.valid    = 1'b1;
            req_o.from_mem = 1'b0;
            req_o.lit      = in_i.in_byte;
            req_o.run_last = 1'b1;
            req_o.blk_end  = in_i.in_last;
            flag_bits_d    = flag_bits_q >> 1;
            flags_left_d   = flags_left_q - 1'b1;
          end else begin
            low_d      = in_i.in_byte;
            await_hi_d = 1'b1;
          end
          if (in_i.in_last) begin
            flag_bits_d  = '0;
            flags_left_d = '0;
            await_hi_d   = 1'b0;
            low_d        = '0;
          end
        end
      end
      lzr_pkg::ST_COPY: begin
        req_o.valid    = 1'b1;
        req_o.from_mem = 1'b1;
        req_o.run_last = (remain_q == LW'(1));
        req_o.blk_end  = mlast_q && (remain_q == LW'(1));
        if (emit_st_i.req_ready) begin
          rd_pos_d = rd_pos_q + 1'b1;
          remain_d = remain_q - 1'b1;
          if (remain_q == LW'(1)) begin
            state_d = lzr_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = lzr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_bits_q  <= '0;
      flags_left_q <= '0;
      await_hi_q   <= 1'b0;
      low_q        <= '0;
      rd_pos_q     <= '0;
      remain_q     <= '0;
      mlast_q      <= 1'b0;
    end else begin
      flag_bits_q  <= flag_bits_d;
      flags_left_q <= flags_left_d;
      await_hi_q   <= await_hi_d;
      low_q        <= low_d;
      rd_pos_q     <= rd_pos_d;
      remain_q     <= remain_d;
      mlast_q      <= mlast_d;
    end
  end

  `LZR_ASSERT_IMP(a_copy_len, state_q == lzr_pkg::ST_COPY, remain_q != '0, "copy with zero length")
  `LZR_ASSERT_IMP(a_copy_blocks_in, state_q == lzr_pkg::ST_COPY, !in_i.ready, "input taken mid copy")
  `LZR_ASSERT_NXT(a_copy_done, (state_q == lzr_pkg::ST_COPY) && emit_st_i.req_ready && (remain_q == LW'(1)), state_q == lzr_pkg::ST_IDLE, "copy did not end")

endmodule

[hw/rtl/lzr_emit.sv]
`include "lzss_ring_decoder_top_defines.svh"

module lzr_emit #(
  parameter int unsigned RING_DEPTH = lzr_pkg::RING_DEPTH,
  parameter int unsigned MAX_MATCH  = lzr_pkg::MAX_MATCH,
  localparam int unsigned AW = $clog2(RING_DEPTH),
  localparam int unsigned CW = AW + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lzr_pkg::lzr_req_t          req_i,
  input  logic [AW-1:0]              req_addr_i,
  input  lzr_pkg::lzr_ctl_t          ctl_i,
  output lzr_pkg::lzr_emit_st_t      emit_st_o,
  lzr_cfg_if.sink                    cfg_i,
  lzr_out_if.source                  out_o,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [lzr_pkg::BYTE_W-1:0] mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [lzr_pkg::BYTE_W-1:0] mem_rdata_i
);

  localparam logic [AW-1:0] WP_INIT = AW'(RING_DEPTH - MAX_MATCH);

  // block state
  logic [lzr_pkg::BYTE_W-1:0] fill_q, blk_fill_q, blk_fill_d;
  logic [AW-1:0]              wp_q, wp_d;
  logic [CW-1:0]              count_q, count_d;
  logic                       at_start_q, at_start_d;

  // data stage (ring read data arrives here)
  logic                       d_valid_q, d_valid_d;
  logic                       d_from_mem_q, d_hit_q, d_fwd_q;
  logic                       d_run_last_q, d_end_q;
  logic [lzr_pkg::BYTE_W-1:0] d_lit_q, d_fwd_data_q;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic [lzr_pkg::BYTE_W-1:0] out_byte_q;
  logic                       out_last_q;

  logic                       d_adv, req_take, cfg_wr, reinit;
  logic [lzr_pkg::BYTE_W-1:0] d_val;
  logic [AW-1:0]              off;
  logic                       hit, fwd;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  assign d_adv    = d_valid_q && (!out_valid_q || out_o.ready);
  assign req_take = req_i.valid && (!d_valid_q || d_adv);

  assign emit_st_o.req_ready = !d_valid_q || d_adv;
  assign emit_st_o.idle      = !d_valid_q;

  always_comb begin
    priority if (d_fwd_q) begin
      d_val = d_fwd_data_q;
    end else if (!d_from_mem_q) begin
      d_val = d_lit_q;
    end else if (d_hit_q) begin
      d_val = mem_rdata_i;
    end else begin
      d_val = blk_fill_q;
    end
  end

  // Writes run sequentially from WP_INIT, so the entries written this block
  // are the first count_q positions from there; the rest still hold the fill.
  assign off = req_addr_i - WP_INIT;
  assign hit = count_q[AW] || ({1'b0, off} < count_q);
  assign fwd = d_adv && (req_addr_i == wp_q);

  assign mem_we_o    = d_adv;
  assign mem_waddr_o = wp_q;
  assign mem_wdata_o = d_val;
  assign mem_re_o    = req_take && req_i.from_mem;
  assign mem_raddr_o = req_addr_i;

  assign reinit = ctl_i.restart || (d_adv && d_end_q);

  always_comb begin
    wp_d       = wp_q;
    count_d    = count_q;
    blk_fill_d = blk_fill_q;
    at_start_d = at_start_q;
    if (d_adv) begin
      wp_d = wp_q + 1'b1;
      if (!count_q[AW]) begin
        count_d = count_q + 1'b1;
      end
    end
    if (ctl_i.take) begin
      at_start_d = 1'b0;
    end
    if (cfg_wr && at_start_q) begin
      blk_fill_d = cfg_i.fill_byte;
    end
    if (reinit) begin
      wp_d       = WP_INIT;
      count_d    = '0;
      blk_fill_d = fill_q;
      at_start_d = 1'b1;
    end
  end

  always_comb begin
    d_valid_d = d_valid_q;
    if (req_take) begin
      d_valid_d = 1'b1;
    end else if (d_adv) begin
      d_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (d_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= lzr_pkg::FILL_RESET;
      blk_fill_q  <= lzr_pkg::FILL_RESET;
      wp_q        <= WP_INIT;
      count_q     <= '0;
      at_start_q  <= 1'b1;
      d_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        fill_q <= cfg_i.fill_byte;
      end
      blk_fill_q  <= blk_fill_d;
      wp_q        <= wp_d;
      count_q     <= count_d;
      at_start_q  <= at_start_d;
      d_valid_q   <= d_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      d_from_mem_q <= req_i.from_mem;
      d_lit_q      <= req_i.lit;
      d_run_last_q <= req_i.run_last;
      d_end_q      <= req_i.blk_end;
      d_hit_q      <= hit;
      d_fwd_q      <= fwd;
      d_fwd_data_q <= d_val;
    end
    if (d_adv) begin
      out_byte_q <= d_val;
      out_last_q <= d_run_last_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.out_run_last = out_last_q;

  `LZR_ASSERT_IMP(a_cnt_range, 1'b1, count_q <= CW'(RING_DEPTH), "fill count overflow")
  `LZR_ASSERT_NXT(a_out_load, d_adv, out_valid_q, "word lost at output")
  `LZR_ASSERT_IMP(a_no_write_at_start, d_adv, !at_start_q, "ring write before first word")
  `LZR_ASSERT_IMP(a_fwd_mem_only, d_valid_q && d_fwd_q, d_from_mem_q, "forward on literal")

endmodule

[hw/rtl/lzss_ring_decoder_top.sv]
// LZSS decoder, 4096-byte history ring, matches of 3 to 18 bytes. Compressed
// words enter one at a time; a word is taken only when the previous one has
// finished issuing its bytes. Flag and match-low words emit no bytes, a
// literal emits one byte and a match of L bytes issues L ring reads. The ring
// memory does one read and one write per cycle unless the output stalls.
// Output is registered, so a stall on the output holds the copy without losing
// bytes. The ring needs no clearing: a per-block write count marks which
// entries are still at the fill byte, so block start and fill_byte writes take
// effect at once. fill_byte written mid-block applies from the next block on.
module lzss_ring_decoder_top #(
  parameter int unsigned RING_DEPTH  = lzr_pkg::RING_DEPTH,
  parameter int unsigned MAX_MATCH   = lzr_pkg::MAX_MATCH,
  parameter int unsigned LENGTH_BIAS = lzr_pkg::LENGTH_BIAS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lzr_in_if.sink    in_i,
  lzr_out_if.source out_o,
  lzr_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(RING_DEPTH);

  lzr_pkg::lzr_req_t          req;
  lzr_pkg::lzr_ctl_t          ctl;
  lzr_pkg::lzr_emit_st_t      emit_st;
  logic [AW-1:0]              req_addr;
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [lzr_pkg::BYTE_W-1:0] mem_wdata, mem_rdata;

  lzr_parser #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_MATCH  (MAX_MATCH),
    .LENGTH_BIAS(LENGTH_BIAS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .emit_st_i (emit_st),
    .req_o     (req),
    .req_addr_o(req_addr),
    .ctl_o     (ctl)
  );

  lzr_emit #(
    .RING_DEPTH(RING_DEPTH),
    .MAX_MATCH (MAX_MATCH)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .req_addr_i (req_addr),
    .ctl_i      (ctl),
    .emit_st_o  (emit_st),
    .cfg_i      (cfg_i),
    .out_o      (out_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  lzr_ring_mem #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

[tb/sv/tb.sv]
module tb;

  localparam int unsigned PERIOD       = 20;
  localparam int unsigned SETTLE_WAIT  = 40;    // covers a match of 18 plus pipeline
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned TOTAL_WORDS  = 460;   // directed part included
  localparam int unsigned CALM_AFTER   = 410;

  typedef logic [lzr_pkg::BYTE_W-1:0] octet_t;

  typedef struct packed {
    octet_t data;
    logic   run_last;
  } decoded_t;

  typedef enum {
    END_CLEAN,
    END_CUT_MATCH,
    END_ON_FLAG
  } block_end_e;

  // Mirror of the decoder: history ring, group flags and match parsing.
  class lzss_scoreboard;
    octet_t      ring [lzr_pkg::RING_DEPTH];
    logic [11:0] wr_pos;
    octet_t      flags;
    logic [3:0]  flags_left;
    bit          want_high;
    octet_t      low_byte;
    octet_t      fill;
    bit          fresh;
    decoded_t    expected_q [$];
    int          errors;
    int          checked;
    int          literals;
    int          match_count;
    int          blocks;

    function new();
      errors      = 0;
      checked     = 0;
      literals    = 0;
      match_count = 0;
      blocks      = 0;
      fill        = lzr_pkg::FILL_RESET;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < lzr_pkg::RING_DEPTH; i++) ring[i] = fill;
      wr_pos     = 12'(lzr_pkg::RING_DEPTH - lzr_pkg::MAX_MATCH);
      flags      = '0;
      flags_left = '0;
      want_high  = 1'b0;
      low_byte   = '0;
      fresh      = 1'b1;
    endfunction

    function void put_byte(octet_t v, logic run_last);
      decoded_t d;
      d.data     = v;
      d.run_last = run_last;
      expected_q = {expected_q, d};
      ring[wr_pos] = v;
      wr_pos = wr_pos + 12'd1;
    endfunction

    function void set_fill(octet_t v);
      fill = v;
      if (fresh) restart();
    endfunction

    function void note_word(octet_t b, logic last);
      logic [11:0] pos;
      logic [11:0] rd;
      int          len;
      int          k;
      fresh = 1'b0;
      if (flags_left == 0) begin
        flags      = b;
        flags_left = lzr_pkg::FLAGS_PER_GROUP;
      end else if (want_high) begin
        pos = {b[7:4], low_byte};
        len = int'(b[3:0]) + lzr_pkg::LENGTH_BIAS + 1;
        for (k = 0; k < len; k++) begin
          rd = pos + 12'(k);
          put_byte(ring[rd], k == len - 1);   // reads see bytes written earlier in the copy
        end
        match_count++;
        want_high  = 1'b0;
        flags      = flags >> 1;
        flags_left = flags_left - 4'd1;
      end else if (flags[0]) begin
        put_byte(b, 1'b1);
        literals++;
        flags      = flags >> 1;
        flags_left = flags_left - 4'd1;
      end else begin
        low_byte  = b;
        want_high = 1'b1;
      end
      if (last) begin
        blocks++;
        restart();
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_byte(octet_t got, logic got_last);
      decoded_t exp_d;
      if (expected_q.size() == 0) begin
        report($sformatf("output word %02h/%0b with nothing expected", got, got_last));
      end else begin
        exp_d = expected_q.pop_front();
        if (got !== exp_d.data)
          report($sformatf("byte %0d out_byte %02h, want %02h", checked, got, exp_d.data));
        if (got_last !== exp_d.run_last)
          report($sformatf("byte %0d out_run_last %0b, want %0b", checked, got_last,
                           exp_d.run_last));
      end
      checked++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  lzr_in_if  in_if ();
  lzr_out_if out_if ();
  lzr_cfg_if cfg_if ();

  lzss_ring_decoder_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  lzss_scoreboard dec_sb;
  int             words_sent;
  int             fill_writes;
  int             quiet_cycles;
  bit             calm;

  initial begin
    clk_i = 1'b0;
    forever #(PERIOD / 2) clk_i = ~clk_i;
  end

  task automatic send_word(input octet_t b, input logic last);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    dec_sb.note_word(b, last);
    words_sent++;
    if (words_sent >= CALM_AFTER) calm = 1'b1;
  endtask

  // Input idle, all expected bytes out, then time for a word that emits nothing.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (dec_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_fill(input octet_t v);
    cfg_if.valid     <= 1'b1;
    cfg_if.fill_byte <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    dec_sb.set_fill(v);
    fill_writes++;
  endtask

  task automatic send_match(input logic [11:0] pos, input logic [3:0] nib, input logic last);
    send_word(pos[7:0], 1'b0);
    send_word({pos[11:4 + 4], nib}, last);
  endtask

  function automatic logic [11:0] pick_pos();
    if ($urandom_range(0, 3) == 0) return 12'($urandom);
    return dec_sb.wr_pos - 12'($urandom_range(1, 24));  // short distances overlap
  endfunction

  function automatic octet_t pick_fill();
    case ($urandom_range(0, 2))
      0: return 8'h00;
      1: return 8'hFF;
      default: return octet_t'($urandom);
    endcase
  endfunction

  task automatic send_block(input int n_items, input block_end_e ending);
    octet_t      flag;
    logic [11:0] pos;
    int          done;
    int          k;
    bit          fin;
    done = 0;
    while (done < n_items) begin
      flag = octet_t'($urandom);
      if (ending == END_CUT_MATCH && n_items - done <= 8) flag[n_items - done - 1] = 1'b0;
      send_word(flag, 1'b0);
      for (k = 0; k < 8 && done < n_items; k++) begin
        fin = (done == n_items - 1) && (ending != END_ON_FLAG);
        if (!fin && $urandom_range(0, 50) == 0) begin
          // fill change mid-block, takes effect at next block
          settle();
          write_fill(pick_fill());
        end
        if (flag[k]) begin
          send_word(octet_t'($urandom), fin);
        end else begin
          pos = pick_pos();
          if (fin && ending == END_CUT_MATCH) send_word(pos[7:0], 1'b1);
          else send_match(pos, 4'($urandom), fin);
        end
        done++;
      end
    end
    if (ending == END_ON_FLAG) send_word(octet_t'($urandom), 1'b1);
  endtask

  task automatic send_noise(input int n);
    int i;
    for (i = 0; i < n; i++)
      send_word(octet_t'($urandom), (i == n - 1) || ($urandom_range(0, 15) == 0));
  endtask

  task automatic run_directed();
    int i;
    write_fill(8'h00);
    // literal, wrapping match of 18, literal, overlapping match, match cut by block end
    send_word(8'h05, 1'b0);
    send_word(8'h00, 1'b0);
    send_match(12'hFFF, 4'hF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_match(dec_sb.wr_pos - 12'd1, 4'h0, 1'b0);
    send_word(8'h77, 1'b1);
    settle();
    write_fill(8'hFF);
    // fill written mid-block: the match still reads the old fill
    send_word(8'hFD, 1'b0);
    send_word(8'h5A, 1'b0);
    settle();
    write_fill(8'hA5);
    send_match(12'h000, 4'h0, 1'b0);
    send_word(8'h80, 1'b1);
    // full group, then a flag word that ends the block
    send_word(8'hFE, 1'b0);
    send_match(12'h534, 4'hF, 1'b0);
    for (i = 1; i < 8; i++) send_word(octet_t'(i * 37), 1'b0);
    send_word(8'h00, 1'b1);
    settle();
    write_fill(lzr_pkg::FILL_RESET);
  endtask

  initial begin
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 5);
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      dec_sb.check_byte(out_if.out_byte, out_if.out_run_last);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pick;
    dec_sb      = new();
    words_sent  = 0;
    fill_writes = 0;
    calm        = 1'b0;
    quiet_cycles <= 0;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.in_byte    <= '0;
    in_if.in_last    <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.fill_byte <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    while (words_sent < TOTAL_WORDS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) send_block($urandom_range(1, 14), END_CLEAN);
      else if (pick == 7) send_block($urandom_range(1, 10), END_CUT_MATCH);
      else if (pick == 8) send_block(8 * $urandom_range(0, 2), END_ON_FLAG);
      else send_noise($urandom_range(1, 12));
      if ($urandom_range(0, 5) == 0) begin
        settle();
        write_fill(pick_fill());
      end
    end

    settle();
    $display("%0d compressed words in %0d blocks: %0d literals, %0d matches",
             words_sent, dec_sb.blocks, dec_sb.literals, dec_sb.match_count);
    $display("%0d decoded bytes checked, %0d fill_byte writes, %0d mismatches",
             dec_sb.checked, fill_writes, dec_sb.errors);
    if (dec_sb.errors == 0 && dec_sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/lzr_pkg.sv
hw/rtl/lzr_in_if.sv
hw/rtl/lzr_out_if.sv
hw/rtl/lzr_cfg_if.sv
hw/rtl/lzr_ring_mem.sv
hw/rtl/lzr_parser.sv
hw/rtl/lzr_emit.sv
hw/rtl/lzss_ring_decoder_top.sv
tb/sv/tb.sv
